>>> rtl/kse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe spacing enforcer package
// Field widths, request codes and the microcode program of the sequencer.
// ----------------------------------------------------------------------------
package kse_pkg;

  // Field widths of the request and result channels.
  localparam int MODE_W = 2;
  localparam int SLOT_W = 7;
  localparam int VAL_W  = 16;
  localparam int CNT_W  = 7;
  // Slot pointer of the sweeps; one bit wider so that it can hold 128.
  localparam int J_W    = SLOT_W + 1;
  localparam int PC_W   = 4;

  // Request codes.
  localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ENFORCE = 2'd2;

  // Full scale of the unit interval.
  localparam logic [VAL_W-1:0] UNIT_MAX = 16'hFFFF;

  typedef logic [PC_W-1:0] pc_t;

  // Program addresses.
  localparam pc_t PC_IDLE      = 4'd0;
  localparam pc_t PC_DISP_WR   = 4'd1;
  localparam pc_t PC_DISP_RD   = 4'd2;
  localparam pc_t PC_DISP_ENF  = 4'd3;
  localparam pc_t PC_NO_OP     = 4'd4;
  localparam pc_t PC_WRITE     = 4'd5;
  localparam pc_t PC_RD_ISSUE  = 4'd6;
  localparam pc_t PC_RD_TAKE   = 4'd7;
  localparam pc_t PC_F_INIT    = 4'd8;
  localparam pc_t PC_F_PRIME   = 4'd9;
  localparam pc_t PC_F_STEP    = 4'd10;
  localparam pc_t PC_B_INIT    = 4'd11;
  localparam pc_t PC_B_PRIME   = 4'd12;
  localparam pc_t PC_B_STEP    = 4'd13;
  localparam pc_t PC_EMIT      = 4'd14;
  localparam pc_t PC_EMIT_WAIT = 4'd15;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR_RES,
    OP_NOP,
    OP_WRITE,
    OP_RD_ISSUE,
    OP_RD_TAKE,
    OP_F_INIT,
    OP_F_PRIME,
    OP_F_STEP,
    OP_B_INIT,
    OP_B_PRIME,
    OP_B_STEP,
    OP_EMIT
  } op_e;

  // Jump conditions; when the condition holds the sequencer jumps, else it steps on.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_MODE_WR,
    C_MODE_RD,
    C_MODE_ENF,
    C_FWD_SKIP,
    C_FWD_MORE,
    C_BWD_SKIP,
    C_BWD_MORE,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } uword_t;

  // Status from the datapath that the jump conditions test.
  typedef struct packed {
    logic no_req;
    logic mode_wr;
    logic mode_rd;
    logic mode_enf;
    logic fwd_skip;
    logic fwd_more;
    logic bwd_skip;
    logic bwd_more;
    logic out_free;
  } seq_flags_t;

  // The control program.
  function automatic uword_t ucode_rom(pc_t pc);
    uword_t w;
    unique case (pc)
      PC_IDLE:      w = '{op: OP_IDLE,      cond: C_NO_REQ,   target: PC_IDLE};
      PC_DISP_WR:   w = '{op: OP_CLEAR_RES, cond: C_MODE_WR,  target: PC_WRITE};
      PC_DISP_RD:   w = '{op: OP_NOP,       cond: C_MODE_RD,  target: PC_RD_ISSUE};
      PC_DISP_ENF:  w = '{op: OP_NOP,       cond: C_MODE_ENF, target: PC_F_INIT};
      PC_NO_OP:     w = '{op: OP_NOP,       cond: C_ALWAYS,   target: PC_EMIT};
      PC_WRITE:     w = '{op: OP_WRITE,     cond: C_ALWAYS,   target: PC_EMIT};
      PC_RD_ISSUE:  w = '{op: OP_RD_ISSUE,  cond: C_NEVER,    target: PC_IDLE};
      PC_RD_TAKE:   w = '{op: OP_RD_TAKE,   cond: C_ALWAYS,   target: PC_EMIT};
      PC_F_INIT:    w = '{op: OP_F_INIT,    cond: C_FWD_SKIP, target: PC_B_INIT};
      PC_F_PRIME:   w = '{op: OP_F_PRIME,   cond: C_NEVER,    target: PC_IDLE};
      PC_F_STEP:    w = '{op: OP_F_STEP,    cond: C_FWD_MORE, target: PC_F_STEP};
      PC_B_INIT:    w = '{op: OP_B_INIT,    cond: C_BWD_SKIP, target: PC_EMIT};
      PC_B_PRIME:   w = '{op: OP_B_PRIME,   cond: C_NEVER,    target: PC_IDLE};
      PC_B_STEP:    w = '{op: OP_B_STEP,    cond: C_BWD_MORE, target: PC_B_STEP};
      PC_EMIT:      w = '{op: OP_EMIT,      cond: C_OUT_FREE, target: PC_IDLE};
      PC_EMIT_WAIT: w = '{op: OP_NOP,       cond: C_ALWAYS,   target: PC_EMIT};
      default:      w = '{op: OP_IDLE,      cond: C_ALWAYS,   target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/kse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kse_ram #(
  parameter int  WIDTH  = 16,
  parameter int  DEPTH  = 63,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/kse_useq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe spacing enforcer sequencer
// Step counter over the control program with conditional jumps.
// ----------------------------------------------------------------------------
module kse_useq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kse_pkg::seq_flags_t flags_i,
  output kse_pkg::uword_t     uword_o
);
  import kse_pkg::*;

  pc_t    pc_q, pc_d;
  uword_t uw;
  logic   take;

  // Fetch the control word and test its jump condition.
  always_comb begin
    uw = ucode_rom(pc_q);
    unique case (uw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_REQ:   take = flags_i.no_req;
      C_MODE_WR:  take = flags_i.mode_wr;
      C_MODE_RD:  take = flags_i.mode_rd;
      C_MODE_ENF: take = flags_i.mode_enf;
      C_FWD_SKIP: take = flags_i.fwd_skip;
      C_FWD_MORE: take = flags_i.fwd_more;
      C_BWD_SKIP: take = flags_i.bwd_skip;
      C_BWD_MORE: take = flags_i.bwd_more;
      C_OUT_FREE: take = flags_i.out_free;
      default:    take = 1'b1;
    endcase
    pc_d = take ? uw.target : pc_q + pc_t'(1);
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign uword_o = uw;

endmodule

>>> rtl/keyframe_spacing_enforcer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe spacing enforcer
// Breakpoint table with write, read and minimum spacing enforcement requests.
// ----------------------------------------------------------------------------
// Usage. Requests enter on the in_ channel (valid/stall) carrying mode, slot,
// value and min_spacing; each request gives exactly one result on the out_
// channel (valid/stall) with read_value and status. interval_count is written
// through cfg_we_i/cfg_wdata_i while no request is in flight.
// One request is handled at a time by a microcoded sequencer over a single
// breakpoint RAM. A write or a read passes through dispatch and its own steps
// to the emit step; an enforce runs a forward and then a backward sweep, each
// opened by a priming step and skipped when it has no slot to visit. The
// sequencer returns to idle at the edge that registers the result. The RAM,
// one read-modify-write per slot per cycle, sets the enforce time.
// After reset the RAM is swept to zero, one entry a cycle, during which
// in_stall_o stays high; configuration writes are taken during that sweep.
// The result sits in an output register, so a stalled receiver does not block
// acceptance of the next request; the sequencer then holds only at its emit
// and emit-wait steps until the register is free.
// ----------------------------------------------------------------------------
module keyframe_spacing_enforcer_top #(
  parameter int MAX_INTERVALS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration
  input  logic                       cfg_we_i,
  input  logic [kse_pkg::CNT_W-1:0]  cfg_wdata_i,
  // Request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [kse_pkg::MODE_W-1:0] mode_i,
  input  logic [kse_pkg::SLOT_W-1:0] slot_i,
  input  logic [kse_pkg::VAL_W-1:0]  value_i,
  input  logic [kse_pkg::VAL_W-1:0]  min_spacing_i,
  // Result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [kse_pkg::VAL_W-1:0]  read_value_o,
  output logic                       status_o
);
  import kse_pkg::*;

  localparam int DEPTH   = MAX_INTERVALS - 1;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_CAP = (MAX_INTERVALS < (1 << CNT_W)) ? MAX_INTERVALS : (1 << CNT_W) - 1;

  // Control state.
  logic [CNT_W-1:0]  count_q;
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_idx_q;
  logic              out_valid_q;

  // Request and working registers.
  logic [MODE_W-1:0] mode_q;
  logic [SLOT_W-1:0] slot_q;
  logic [VAL_W-1:0]  value_q;
  logic [VAL_W-1:0]  sp_q;
  logic [J_W-1:0]    j_q;
  logic [VAL_W-1:0]  nb_q;
  logic [VAL_W-1:0]  res_rd_q;
  logic              res_st_q;
  logic [VAL_W-1:0]  out_rd_q;
  logic              out_st_q;

  uword_t            uw;
  seq_flags_t        flags;

  logic [CNT_W-1:0]  eff_cnt;
  logic [J_W-1:0]    n_w;
  logic [J_W-1:0]    slot_w;
  logic [J_W-1:0]    jb;
  logic              wr_in_range;
  logic              accept;
  logic              out_free;
  logic              out_load;

  logic [VAL_W:0]    f_sum;
  logic [VAL_W-1:0]  f_floor;
  logic [VAL_W-1:0]  f_new;
  logic [VAL_W-1:0]  b_ceil;
  logic [VAL_W-1:0]  b_new;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  // The count is capped at the table size.
  assign eff_cnt = (count_q > CNT_W'(CNT_CAP)) ? CNT_W'(CNT_CAP) : count_q;
  assign n_w     = {1'b0, eff_cnt};
  assign slot_w  = {1'b0, slot_q};
  // The backward sweep starts at the key slot, or at the count if the key lies beyond.
  assign jb      = (slot_w < n_w) ? slot_w : n_w;
  assign wr_in_range = (slot_q != '0) && (slot_w < n_w);

  // Handshakes.
  assign in_stall_o = !((uw.op == OP_IDLE) && !clr_busy_q);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (uw.op == OP_EMIT) && out_free;

  // Forward step: raise to the left neighbour plus spacing, saturated at full scale.
  assign f_sum   = {1'b0, nb_q} + {1'b0, sp_q};
  assign f_floor = f_sum[VAL_W] ? UNIT_MAX : f_sum[VAL_W-1:0];
  assign f_new   = (ram_rdata >= f_floor) ? ram_rdata : f_floor;

  // Backward step: lower to the right neighbour minus spacing, saturated at zero.
  assign b_ceil  = (nb_q >= sp_q) ? nb_q - sp_q : '0;
  assign b_new   = (ram_rdata <= b_ceil) ? ram_rdata : b_ceil;

  // Flags for the jump conditions.
  always_comb begin
    flags.no_req   = !accept;
    flags.mode_wr  = (mode_q == MODE_WRITE);
    flags.mode_rd  = (mode_q == MODE_READ);
    flags.mode_enf = (mode_q == MODE_ENFORCE);
    flags.fwd_skip = ((slot_w + J_W'(1)) >= n_w);
    flags.fwd_more = ((j_q + J_W'(1)) < n_w);
    flags.bwd_skip = (jb <= J_W'(1));
    flags.bwd_more = (j_q > J_W'(2));
    flags.out_free = out_free;
  end

  kse_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uw)
  );

  // RAM port control; slot j lives at entry j-1.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(slot_w - J_W'(1));
    ram_wdata = value_q;
    ram_raddr = ADDR_W'(slot_w - J_W'(1));
    unique case (uw.op)
      OP_WRITE: begin
        ram_we = wr_in_range;
      end
      OP_F_PRIME: begin
        ram_raddr = ADDR_W'(j_q - J_W'(1));
      end
      OP_F_STEP: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(j_q - J_W'(1));
        ram_wdata = f_new;
        ram_raddr = ADDR_W'(j_q);
      end
      OP_B_INIT: begin
        ram_raddr = ADDR_W'(jb - J_W'(1));
      end
      OP_B_PRIME: begin
        ram_raddr = ADDR_W'(j_q - J_W'(2));
      end
      OP_B_STEP: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(j_q - J_W'(2));
        ram_wdata = b_new;
        ram_raddr = ADDR_W'(j_q - J_W'(3));
      end
      default: begin
      end
    endcase
    // The clearing sweep after reset owns the write port.
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_q;
      ram_wdata = '0;
    end
  end

  kse_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control registers: count, clearing sweep and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CNT_W'(1);
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (clr_busy_q) begin
        if (clr_idx_q == ADDR_W'(DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end else begin
          clr_idx_q <= clr_idx_q + ADDR_W'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers driven by the control word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      slot_q  <= slot_i;
      value_q <= value_i;
      sp_q    <= min_spacing_i;
    end
    unique case (uw.op)
      OP_CLEAR_RES: begin
        res_rd_q <= '0;
        res_st_q <= 1'b0;
      end
      OP_WRITE: begin
        res_st_q <= !wr_in_range;
      end
      OP_RD_TAKE: begin
        // Slot zero reads zero and slots at or beyond the count read full scale.
        if (slot_q == '0) begin
          res_rd_q <= '0;
        end else if (slot_w >= n_w) begin
          res_rd_q <= UNIT_MAX;
        end else begin
          res_rd_q <= ram_rdata;
        end
      end
      OP_F_INIT: begin
        j_q <= slot_w + J_W'(1);
      end
      OP_F_PRIME: begin
        nb_q <= (slot_q == '0) ? '0 : ram_rdata;
      end
      OP_F_STEP: begin
        nb_q <= f_new;
        j_q  <= j_q + J_W'(1);
      end
      OP_B_INIT: begin
        j_q <= jb;
      end
      OP_B_PRIME: begin
        nb_q <= (j_q >= n_w) ? UNIT_MAX : ram_rdata;
      end
      OP_B_STEP: begin
        nb_q <= b_new;
        j_q  <= j_q - J_W'(1);
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_rd_q <= res_rd_q;
      out_st_q <= res_st_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_rd_q;
  assign status_o     = out_st_q;

endmodule

>>> rtl/kse_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe spacing enforcer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module kse_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [kse_pkg::VAL_W-1:0]  read_value_o,
  input logic                       status_o
);

  // A stalled result stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(read_value_o) && $stable(status_o))
    else $error("result payload changed while stalled");

  // Requests are handled one at a time, so acceptance closes the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request accepted while one is in flight");

  // A new result is only loaded while the input is closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in flight");

endmodule

bind keyframe_spacing_enforcer_top kse_chk u_kse_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .read_value_o (read_value_o),
  .status_o     (status_o)
);

>>> tb/tb_keyframe_spacing_enforcer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe spacing enforcer testbench
// Drives write, read, enforce and unused requests through the valid/stall
// request channel and checks every result against a cycle-free model of the
// breakpoint table. Several interval counts are used, including zero, one and
// values above the table size. Both channels pause in random bursts, and the
// final phase runs without pauses.
// ----------------------------------------------------------------------------
module tb_keyframe_spacing_enforcer_top;
  import kse_pkg::*;

  localparam int          MAX_INT     = 64;
  localparam int          CLK_HALF    = 6;
  localparam int          SETTLE      = 8;
  localparam int          TAIL_CYCLES = 20;
  localparam int          CYCLE_LIMIT = 1_200_000;
  localparam int          PHASE_ITEMS = 235;
  localparam int          MISMATCH_SHOWN = 10;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [VAL_W-1:0] read_value;
    logic             status;
  } bp_reply_t;

  // DUT signals.
  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CNT_W-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [MODE_W-1:0]   mode_i;
  logic [SLOT_W-1:0]   slot_i;
  logic [VAL_W-1:0]    value_i;
  logic [VAL_W-1:0]    min_spacing_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [VAL_W-1:0]    read_value_o;
  logic                status_o;

  // Model of the breakpoint table and the interval count.
  logic [VAL_W-1:0]    table_model [1:MAX_INT-1];
  int unsigned         count_model;

  bp_reply_t           pending_replies[$];
  int unsigned         requests_sent;
  int unsigned         replies_seen;
  int unsigned         fail_count;
  int unsigned         cycle_count;
  int unsigned         gap_pct;
  int unsigned         stall_pct;
  bit                  quiet_run;

  keyframe_spacing_enforcer_top #(
    .MAX_INTERVALS(MAX_INT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .slot_i        (slot_i),
    .value_i       (value_i),
    .min_spacing_i (min_spacing_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o),
    .status_o      (status_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_keyframe_spacing_enforcer_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Table model
  // ---------------------------------------------------------------------------

  // Interval counts above the table size are clamped to it.
  function automatic int unsigned active_count();
    return (count_model > MAX_INT) ? MAX_INT : count_model;
  endfunction

  // Slot 0 reads as zero and slots at or above the count read as full scale.
  function automatic int unsigned slot_value(int unsigned s);
    if (s == 0) return 0;
    if (s >= active_count()) return 32'(UNIT_MAX);
    return 32'(table_model[s]);
  endfunction

  function automatic void store_slot(int unsigned s, int unsigned v);
    if (s >= 1 && s < active_count())
      table_model[s] = (v > 32'(UNIT_MAX)) ? UNIT_MAX : VAL_W'(v);
  endfunction

  // Forward sweep pushes later slots up, backward sweep pulls earlier ones down.
  function automatic void enforce_spacing(int unsigned key, int unsigned gap);
    int unsigned j;
    int unsigned bound;
    int unsigned cur;
    for (j = key + 1; j < active_count(); j++) begin
      bound = slot_value(j - 1) + gap;
      cur   = slot_value(j);
      store_slot(j, (cur >= bound) ? cur : bound);
    end
    for (j = key; j > 1; j--) begin
      bound = slot_value(j);
      bound = (bound >= gap) ? bound - gap : 0;
      cur   = slot_value(j - 1);
      store_slot(j - 1, (cur <= bound) ? cur : bound);
    end
  endfunction

  // Applies one request to the model and returns the reply it should give.
  function automatic bp_reply_t apply_table_request(logic [MODE_W-1:0] mode,
                                                    logic [SLOT_W-1:0] slot,
                                                    logic [VAL_W-1:0]  value,
                                                    logic [VAL_W-1:0]  gap);
    bp_reply_t r;
    r.read_value = '0;
    r.status     = 1'b0;
    case (mode)
      MODE_WRITE: begin
        if (slot >= 1 && slot < active_count()) table_model[slot] = value;
        else r.status = 1'b1;
      end
      MODE_READ:    r.read_value = VAL_W'(slot_value(slot));
      MODE_ENFORCE: enforce_spacing(slot, gap);
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------

  // Sends one request, with an optional random pause before it, and records
  // the reply expected once the request is accepted.
  task automatic send_request(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                              logic [VAL_W-1:0] value, logic [VAL_W-1:0] gap);
    if (!quiet_run && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    slot_i        <= slot;
    value_i       <= value;
    min_spacing_i <= gap;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    pending_replies.push_back(apply_table_request(mode, slot, value, gap));
    requests_sent++;
  endtask

  // Holds off new requests until every reply has been returned.
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_interval_count(logic [CNT_W-1:0] cnt);
    cfg_wdata_i <= cnt;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    count_model = cnt;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic note_failure(string what, int unsigned want, int unsigned got);
    fail_count++;
    if (fail_count <= MISMATCH_SHOWN)
      $display("reply %0d: %s expected %0d, got %0d", replies_seen, what, want, got);
  endtask

  always @(posedge clk_i) begin : check_replies
    bp_reply_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_replies.size() == 0) begin
        note_failure("unexpected reply, queue depth", 0, 1);
      end else begin
        want = pending_replies.pop_front();
        if (read_value_o !== want.read_value)
          note_failure("read_value", want.read_value, read_value_o);
        if (status_o !== want.status)
          note_failure("status", want.status, status_o);
      end
      replies_seen++;
    end
  end

  // Receiver back-pressure in random bursts.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet_run && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Count of one after reset: no slot is stored.
  task automatic test_reset_defaults();
    send_request(MODE_READ, 7'd0, 16'd0, 16'd0);
    send_request(MODE_READ, 7'd1, 16'd0, 16'd0);
    send_request(MODE_WRITE, 7'd1, 16'd1234, 16'd0);
    send_request(MODE_ENFORCE, 7'd0, 16'd0, 16'd5);
  endtask

  // Count of zero: slot 0 reads zero and everything else full scale.
  task automatic test_empty_table();
    drain_requests();
    write_interval_count(7'd0);
    send_request(MODE_READ, 7'd0, 16'd0, 16'd0);
    send_request(MODE_READ, 7'd77, 16'd0, 16'd0);
    send_request(MODE_WRITE, 7'd0, 16'd99, 16'd0);
    send_request(MODE_WRITE, 7'd1, 16'd99, 16'd0);
    send_request(MODE_ENFORCE, 7'd3, 16'd0, 16'd100);
  endtask

  // Count above the table size, field extremes, saturation and the key at
  // zero and beyond the count.
  task automatic test_field_extremes();
    drain_requests();
    write_interval_count(7'd127);
    send_request(MODE_WRITE, 7'd1, 16'h0000, 16'h0000);
    send_request(MODE_WRITE, 7'd63, 16'hFFFF, 16'hFFFF);
    send_request(MODE_WRITE, 7'd64, 16'h1111, 16'h0000);
    send_request(MODE_WRITE, 7'd127, 16'h5555, 16'h0000);
    send_request(MODE_WRITE, 7'd32, 16'hAAAA, 16'h0000);
    send_request(MODE_READ, 7'd127, 16'h0000, 16'h0000);
    send_request(MODE_READ, 7'd64, 16'h0000, 16'h0000);
    send_request(MODE_UNUSED, 7'd127, 16'hFFFF, 16'hFFFF);
    send_request(MODE_ENFORCE, 7'd0, 16'h0000, 16'hFFFF);
    send_request(MODE_READ, 7'd63, 16'h0000, 16'h0000);
    send_request(MODE_ENFORCE, 7'd127, 16'h0000, 16'd1000);
    send_request(MODE_READ, 7'd62, 16'h0000, 16'h0000);
    send_request(MODE_ENFORCE, 7'd32, 16'h0000, 16'h0000);
    send_request(MODE_READ, 7'd32, 16'h0000, 16'h0000);
    send_request(MODE_READ, 7'd1, 16'h0000, 16'h0000);
  endtask

  // One random request, mostly aimed at the live slots.
  task automatic random_request();
    int unsigned n;
    int unsigned pick;
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  value;
    logic [VAL_W-1:0]  gap;
    n    = active_count();
    pick = $urandom_range(0, 99);
    if (pick < 35)      mode = MODE_WRITE;
    else if (pick < 70) mode = MODE_READ;
    else if (pick < 95) mode = MODE_ENFORCE;
    else                mode = MODE_UNUSED;
    slot  = ($urandom_range(0, 4) != 0) ? SLOT_W'($urandom_range(0, n))
                                        : SLOT_W'($urandom_range(0, 127));
    value = VAL_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0:       gap = VAL_W'($urandom_range(0, 65535 / (n + 1)));
      1:       gap = VAL_W'($urandom_range(0, 255));
      2:       gap = VAL_W'($urandom_range(0, 65535));
      default: gap = VAL_W'(65535 - $urandom_range(0, 15));
    endcase
    send_request(mode, slot, value, gap);
  endtask

  // Fills part of the table, enforces around one key and reads it all back.
  task automatic spacing_scenario();
    int unsigned n;
    int unsigned fills;
    int unsigned s;
    n     = active_count();
    fills = $urandom_range(1, n - 1);
    repeat (fills)
      send_request(MODE_WRITE, SLOT_W'($urandom_range(1, n - 1)),
                   VAL_W'($urandom_range(0, 65535)), VAL_W'($urandom_range(0, 65535)));
    send_request(MODE_ENFORCE, SLOT_W'($urandom_range(0, n)),
                 VAL_W'($urandom_range(0, 65535)),
                 VAL_W'($urandom_range(0, 2 * 65535 / n)));
    for (s = 0; s <= n; s++)
      send_request(MODE_READ, SLOT_W'(s), VAL_W'($urandom_range(0, 65535)), 16'd0);
  endtask

  // A phase of random traffic at one interval count, with the pause rates
  // changed every few dozen requests.
  task automatic test_random_traffic(logic [CNT_W-1:0] cnt);
    int unsigned target;
    int unsigned reroll;
    drain_requests();
    write_interval_count(cnt);
    target = requests_sent + PHASE_ITEMS;
    reroll = requests_sent;
    while (requests_sent < target) begin
      if (requests_sent >= reroll) begin
        gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
        reroll    = requests_sent + 50;
      end
      if (active_count() >= 2 && $urandom_range(0, 3) == 0) spacing_scenario();
      else random_request();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    mode_i        = MODE_WRITE;
    slot_i        = '0;
    value_i       = '0;
    min_spacing_i = '0;
    requests_sent = 0;
    replies_seen  = 0;
    fail_count    = 0;
    gap_pct       = 20;
    stall_pct     = 20;
    quiet_run     = 1'b0;
    count_model   = 1;
    for (int i = 1; i < MAX_INT; i++) table_model[i] = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_empty_table();
    test_field_extremes();
    test_random_traffic(7'd64);
    test_random_traffic(7'd2);
    test_random_traffic(7'd127);
    test_random_traffic(7'd9);
    test_random_traffic(7'd1);
    test_random_traffic(7'd33);
    test_random_traffic(7'd0);
    // Last phase runs at full rate on both channels.
    quiet_run = 1'b1;
    test_random_traffic(7'd17);

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_replies.size() == 0)
      $display("tb_keyframe_spacing_enforcer_top: PASS");
    else
      $display("tb_keyframe_spacing_enforcer_top: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
rtl/kse_pkg.sv
rtl/kse_ram.sv
rtl/kse_useq.sv
rtl/keyframe_spacing_enforcer_top.sv
rtl/kse_chk.sv
tb/tb_keyframe_spacing_enforcer_top.sv
